@@ sv/wpip_pkg.sv @@
package wpip_pkg;

    // Width of the wrapped shoelace sum.
    localparam int AREA_W = 64;

    // Result field widths and packing.
    localparam int WIND_OUT_W  = 8;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int IN_TUSER_W  = 2;

    // Saturation limits of the winding field.
    localparam int WIND_MAX = 127;
    localparam int WIND_MIN = -128;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd2;

    // Request kinds carried in the input tuser.
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Operations of the shared arithmetic pipeline.
    typedef enum logic [1:0] {
        OP_EDGE,
        OP_AREA_ADD,
        OP_AREA_CLOSE
    } t_op_kind;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_RESULT
    } t_state;

    // Per-cell control of the vertex ring.
    typedef struct packed {
        logic we;
        logic shift;
        logic wrap;
    } t_cell_ctl;

    // What the arithmetic pipeline hands to the accumulators.
    typedef struct packed {
        logic     valid;
        t_op_kind kind;
        logic     up;
        logic     dn;
        logic     busy;
    } t_arith_out;

endpackage

@@ sv/wpip_cell.sv @@
module wpip_cell
    import wpip_pkg::*;
#(
    parameter int VW = 48
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [VW-1:0] i_wr_vtx,
    input  logic [VW-1:0] i_next_vtx,
    input  logic [VW-1:0] i_head_vtx,
    output logic [VW-1:0] o_vtx
);

    logic [VW-1:0] r_vtx;

    // A cell either takes a new vertex or, while the ring turns, the vertex of
    // its neighbor; the last occupied cell closes the ring from the head cell.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_vtx <= i_wr_vtx;
        end else if (i_ctl.shift) begin
            r_vtx <= i_ctl.wrap ? i_head_vtx : i_next_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

@@ sv/wpip_arith.sv @@
module wpip_arith
    import wpip_pkg::*;
#(
    parameter int CW = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    input  t_op_kind          i_op_kind,
    input  logic [2*CW-1:0]   i_vtx_a,
    input  logic [2*CW-1:0]   i_vtx_b,
    input  logic [2*CW-1:0]   i_pnt,
    output t_arith_out        o_res,
    output logic [AREA_W-1:0] o_term
);

    localparam int OW = CW + 1;
    localparam int PW = 2 * OW;

    logic signed [CW-1:0] ax, ay, bx, by, px, py;

    assign ax = i_vtx_a[CW-1:0];
    assign ay = i_vtx_a[2*CW-1:CW];
    assign bx = i_vtx_b[CW-1:0];
    assign by = i_vtx_b[2*CW-1:CW];
    assign px = i_pnt[CW-1:0];
    assign py = i_pnt[2*CW-1:CW];

    // Operand stage: edge differences, or plain coordinates for a cross term.
    logic signed [OW-1:0] n_m1a, n_m1b, n_m2a, n_m2b;

    always_comb begin
        if (i_op_kind == OP_EDGE) begin
            n_m1a = OW'(bx) - OW'(ax);
            n_m1b = OW'(py) - OW'(ay);
            n_m2a = OW'(px) - OW'(ax);
            n_m2b = OW'(by) - OW'(ay);
        end else begin
            n_m1a = OW'(ax);
            n_m1b = OW'(by);
            n_m2a = OW'(bx);
            n_m2b = OW'(ay);
        end
    end

    logic                 r_a_valid, r_b_valid, r_c_valid;
    t_op_kind             r_a_kind, r_b_kind, r_c_kind;
    logic signed [OW-1:0] r_m1a, r_m1b, r_m2a, r_m2b;
    logic                 r_a_le, r_a_gt, r_b_le, r_b_gt;
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_c_up, r_c_dn;
    logic [AREA_W-1:0]    r_term;
    logic [AREA_W-1:0]    n_term;

    assign n_term = AREA_W'(r_p1) - AREA_W'(r_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_op_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_kind <= i_op_kind;
        r_m1a    <= n_m1a;
        r_m1b    <= n_m1b;
        r_m2a    <= n_m2a;
        r_m2b    <= n_m2b;
        r_a_le   <= (ay <= py);
        r_a_gt   <= (by > py);

        r_b_kind <= r_a_kind;
        r_p1     <= r_m1a * r_m1b;
        r_p2     <= r_m2a * r_m2b;
        r_b_le   <= r_a_le;
        r_b_gt   <= r_a_gt;

        // Upward crossing with the point to the left counts +1, a downward
        // crossing with the point to the right counts -1.
        r_c_kind <= r_b_kind;
        r_c_up   <= r_b_le & r_b_gt & (r_p1 > r_p2);
        r_c_dn   <= ~r_b_le & ~r_b_gt & (r_p1 < r_p2);
        r_term   <= n_term;
    end

    assign o_res.valid = r_c_valid;
    assign o_res.kind  = r_c_kind;
    assign o_res.up    = r_c_up;
    assign o_res.dn    = r_c_dn;
    assign o_res.busy  = r_a_valid | r_b_valid | r_c_valid;
    assign o_term      = r_term;

endmodule

@@ sv/winding_point_in_polygon.sv @@
// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready   i_s_tdata: x, y; i_s_tuser: type, first
// m         out        o_m_tvalid / i_m_tready   o_m_tdata: inside, winding, ccw, status
//
// An append that starts an outline or is dropped leaves the controller idle;
// one that adds a shoelace term waits in the drain state for the pipeline to
// empty. A query over n stored vertices turns the vertex ring one position per
// cycle past the single edge unit, then the three-stage pipeline drains and
// the result loads; a query with fewer than three vertices skips the walk.
// Reset is synchronous and active low; no clearing pass follows it.
// A result waiting on the output register does not block new input
// transactions; only loading the next result waits for it to be taken.
module winding_point_in_polygon
    import wpip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // coord_x [COORD_WIDTH-1:0], coord_y next, then zero fill to bytes.
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // req_type [0], first_vertex [1].
    input  logic [IN_TUSER_W-1:0]                  i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // inside_res [0], winding [8:1], counter_clockwise [9], status [11:10].
    output logic [OUT_TDATA_W-1:0]                 o_m_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int VW    = 2 * CW;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int WW    = $clog2(MAX_VERTICES + 1) + 1;

    // Input fields.
    logic          in_type;
    logic          in_first;
    logic [VW-1:0] in_pnt;

    assign in_type  = i_s_tuser[0];
    assign in_first = i_s_tuser[1];
    assign in_pnt   = i_s_tdata[VW-1:0];

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_step;
    logic [AREA_W-1:0]  r_area;
    logic               r_ovf;
    logic               r_is_query;
    logic               r_few;
    logic               r_ccw;
    logic signed [WW-1:0] r_wind;
    logic [VW-1:0]      r_pnt;
    logic [VW-1:0]      r_last;
    logic [VW-1:0]      r_first;

    // Output register.
    logic                  r_out_valid;
    logic                  r_out_inside;
    logic [WIND_OUT_W-1:0] r_out_wind;
    logic                  r_out_ccw;
    logic [STATUS_W-1:0]   r_out_status;

    logic             accept;
    logic             do_append;
    logic             do_query;
    logic [CNT_W-1:0] eff_count;
    logic             app_ok;
    logic             app_term;
    logic             query_few;
    logic             walk_last;
    logic             walk_shift;
    logic             load_out;

    assign accept    = i_s_tvalid & o_s_tready;
    assign do_append = accept & (in_type == REQ_APPEND);
    assign do_query  = accept & (in_type == REQ_QUERY);
    assign eff_count = in_first ? '0 : r_count;
    assign app_ok    = eff_count < CNT_W'(MAX_VERTICES);
    assign app_term  = app_ok & (eff_count != '0);
    assign query_few = r_count < CNT_W'(3);
    assign walk_last = r_step == (r_count - CNT_W'(1));

    // Vertex ring: cell k holds vertex k at rest; during a query the ring turns
    // once per cycle so that cells 0 and 1 present consecutive edges.
    logic [VW-1:0] w_vtx [MAX_VERTICES];
    t_cell_ctl     w_ctl [MAX_VERTICES];

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        assign w_ctl[k].we    = do_append & app_ok & (eff_count == CNT_W'(k));
        assign w_ctl[k].shift = walk_shift;
        assign w_ctl[k].wrap  = r_count == CNT_W'(k + 1);

        wpip_cell #(
            .VW(VW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl[k]),
            .i_wr_vtx  (in_pnt),
            .i_next_vtx(w_vtx[(k + 1) % MAX_VERTICES]),
            .i_head_vtx(w_vtx[0]),
            .o_vtx     (w_vtx[k])
        );
    end

    // Shared arithmetic: edge side tests during the walk, shoelace terms for
    // appends and for the closing edge of a query.
    logic              op_valid;
    t_op_kind          op_kind;
    logic [VW-1:0]     op_vtx_a;
    logic [VW-1:0]     op_vtx_b;
    t_arith_out        arith_res;
    logic [AREA_W-1:0] arith_term;

    assign op_valid = (do_append & app_term) | (do_query & ~query_few) | walk_shift;

    always_comb begin
        if (r_state == S_WALK) begin
            op_kind  = OP_EDGE;
            op_vtx_a = w_vtx[0];
            op_vtx_b = w_vtx[1];
        end else if (in_type == REQ_QUERY) begin
            op_kind  = OP_AREA_CLOSE;
            op_vtx_a = r_last;
            op_vtx_b = r_first;
        end else begin
            op_kind  = OP_AREA_ADD;
            op_vtx_a = r_last;
            op_vtx_b = in_pnt;
        end
    end

    wpip_arith #(
        .CW(CW)
    ) u_arith (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_valid(op_valid),
        .i_op_kind (op_kind),
        .i_vtx_a   (op_vtx_a),
        .i_vtx_b   (op_vtx_b),
        .i_pnt     (r_pnt),
        .o_res     (arith_res),
        .o_term    (arith_term)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (do_query) begin
                    n_state = query_few ? S_RESULT : S_WALK;
                end else if (do_append & app_term) begin
                    n_state = S_DRAIN;
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!arith_res.busy) begin
                    n_state = r_is_query ? S_RESULT : S_IDLE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_tready = 1'b0;
        walk_shift = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE:   o_s_tready = 1'b1;
            S_WALK:   walk_shift = 1'b1;
            S_DRAIN:  ;
            S_RESULT: load_out = ~r_out_valid | i_m_tready;
            default:  ;
        endcase
    end

    // Result fields from the accumulators, winding saturated to the field.
    logic signed [31:0]    wind_ext;
    logic [WIND_OUT_W-1:0] wind_sat;
    logic [AREA_W-1:0]     area_total;

    assign wind_ext   = 32'(r_wind);
    assign area_total = r_area + arith_term;

    always_comb begin
        if (wind_ext > WIND_MAX) begin
            wind_sat = WIND_OUT_W'(WIND_MAX);
        end else if (wind_ext < WIND_MIN) begin
            wind_sat = WIND_OUT_W'(WIND_MIN);
        end else begin
            wind_sat = wind_ext[WIND_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_area      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Appends: a first-vertex mark restarts the outline; past capacity
            // the vertex is dropped and the overflow flag sticks.
            if (do_append) begin
                if (in_first) begin
                    r_area <= '0;
                    r_ovf  <= 1'b0;
                end
                if (!app_ok) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= eff_count + CNT_W'(1);
                end
            end

            if (arith_res.valid && (arith_res.kind == OP_AREA_ADD)) begin
                r_area <= area_total;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pnt      <= in_pnt;
            r_is_query <= in_type;
        end
        if (do_append && app_ok) begin
            r_last <= in_pnt;
            if (eff_count == '0) begin
                r_first <= in_pnt;
            end
        end

        if (do_query) begin
            r_wind <= '0;
            r_ccw  <= 1'b0;
            r_few  <= query_few;
            r_step <= '0;
        end else if (walk_shift) begin
            r_step <= r_step + CNT_W'(1);
        end

        if (arith_res.valid) begin
            case (arith_res.kind)
                OP_EDGE: begin
                    if (arith_res.up) begin
                        r_wind <= r_wind + WW'(1);
                    end else if (arith_res.dn) begin
                        r_wind <= r_wind - WW'(1);
                    end
                end
                OP_AREA_CLOSE: r_ccw <= (area_total != '0) & ~area_total[AREA_W-1];
                OP_AREA_ADD:   ;
                default:       ;
            endcase
        end

        if (load_out) begin
            r_out_inside <= r_wind != '0;
            r_out_wind   <= wind_sat;
            r_out_ccw    <= r_ccw;
            if (r_few) begin
                r_out_status <= ST_FEW;
            end else if (r_ovf) begin
                r_out_status <= ST_OVF;
            end else begin
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_status, r_out_ccw, r_out_wind, r_out_inside});

`ifndef NO_ASSERTIONS
    // The stored vertex count never passes the capacity of the ring.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above capacity");

    // The edge walk only runs over a closed outline of three or more vertices.
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_count >= CNT_W'(3)))
        else $error("edge walk with too few vertices");

    // The pipeline is empty whenever a new transaction may be taken.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !arith_res.busy)
        else $error("arithmetic pipeline busy while idle");

    // A new result only appears after the result state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESULT))
        else $error("result loaded outside the result state");

    // A too-small outline reports no winding and no orientation.
    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FEW)) |->
            (r_out_wind == '0) && !r_out_inside && !r_out_ccw)
        else $error("too-few status with nonzero result");
`endif

endmodule
